// ----- sv/pcb_pkg.sv -----
// pcb_pkg: shared types and operation codes for the ping-pong capture buffer
// no dependencies; used by pcb_store, pcb_ring and the top level

package pcb_pkg;

  localparam logic [2:0] OP_PUSH      = 3'd0;
  localparam logic [2:0] OP_RING_PUSH = 3'd1;
  localparam logic [2:0] OP_FLUSH     = 3'd2;
  localparam logic [2:0] OP_SWAP      = 3'd3;
  localparam logic [2:0] OP_RELEASE   = 3'd4;
  localparam logic [2:0] OP_READ      = 3'd5;
  localparam logic [2:0] OP_CLEAR     = 3'd6;

  typedef struct packed {
    logic [15:0] sample;
    logic [31:0] delta;
  } record_t;

  typedef struct packed {
    logic        push;
    logic        flush;
    record_t     rec;
    logic [63:0] base;
    logic        swap;
    logic        release_buf;
    logic        clear;
    logic        read;
    logic [9:0]  rd_index;
  } store_cmd_t;

  typedef struct packed {
    logic        push_ok;
    logic        refused;
    logic        ready_valid;
    logic [10:0] ready_count;
    logic [63:0] ready_base;
    logic        active_full;
    logic [31:0] overflow;
    logic [31:0] pushed;
    logic        rd_hit;
    record_t     rd_rec;
  } store_stat_t;

  typedef struct packed {
    logic    push;
    record_t rec;
    logic    start;
    logic    step;
    logic    empty;
  } ring_cmd_t;

  typedef struct packed {
    logic       empty;
    logic       more;
    logic [8:0] fill;
    record_t    rd_rec;
  } ring_stat_t;

  typedef struct packed {
    logic        accepted;
    logic        ready_valid;
    logic [10:0] ready_count;
    logic [63:0] ready_base;
    logic [15:0] read_sample;
    logic [31:0] read_delta;
    logic        active_full;
    logic [8:0]  ring_fill;
    logic [31:0] overflow_total;
    logic [31:0] pushed_total;
  } status_item_t;

endpackage

// ----- sv/pcb_capture_if.sv -----
// pcb_capture_if: valid/ready channel carrying one capture operation item
// standalone; used by the top level

interface pcb_capture_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [15:0] sample;
  logic [31:0] delta;
  logic [63:0] first_base_cycles;
  logic [9:0]  read_index;

  modport source (output valid, operation, sample, delta, first_base_cycles, read_index,
                  input ready);
  modport sink (input valid, operation, sample, delta, first_base_cycles, read_index,
                output ready);
endinterface

// ----- sv/pcb_status_if.sv -----
// pcb_status_if: valid/ready channel carrying one status item
// standalone; used by the top level

interface pcb_status_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic        ready_valid;
  logic [10:0] ready_count;
  logic [63:0] ready_base;
  logic [15:0] read_sample;
  logic [31:0] read_delta;
  logic        active_full;
  logic [8:0]  ring_fill;
  logic [31:0] overflow_total;
  logic [31:0] pushed_total;

  modport source (output valid, accepted, ready_valid, ready_count, ready_base, read_sample,
                  read_delta, active_full, ring_fill, overflow_total, pushed_total,
                  input ready);
  modport sink (input valid, accepted, ready_valid, ready_count, ready_base, read_sample,
                read_delta, active_full, ring_fill, overflow_total, pushed_total,
                output ready);
endinterface

// ----- sv/pcb_store.sv -----
// pcb_store: ping-pong record memory with per-buffer bookkeeping and counters
// depends on pcb_pkg; status shows the state as it will be after this cycle

module pcb_store #(
  parameter int BUF_DEPTH = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  pcb_pkg::store_cmd_t cmd,
  output pcb_pkg::store_stat_t stat
);

  localparam int FW  = $clog2(BUF_DEPTH + 1);
  localparam int BAW = $clog2(BUF_DEPTH);
  localparam int CW  = (FW > 10) ? FW : 10;

  // buffer state kept as active and other, the physical index in active
  logic          active, active_next;
  logic          wv, wv_next;
  logic [FW-1:0] a_fill, a_fill_next, o_fill, o_fill_next;
  logic          a_full, a_full_next, o_full, o_full_next;
  logic [63:0]   a_base, a_base_next, o_base, o_base_next;
  logic [31:0]   ovf, ovf_next, pushed, pushed_next;
  logic          push_ok, refused;
  logic          wr_en, wr_sel;
  logic [BAW-1:0] wr_idx, rd_addr;
  logic          hit;
  logic          rd_hit;
  pcb_pkg::record_t rd_rec;

  pcb_pkg::record_t mem [2][BUF_DEPTH];

  assign rd_addr = BAW'(cmd.rd_index);
  assign hit     = wv && (CW'(cmd.rd_index) < CW'(o_fill));

  always_comb begin
    active_next = active;
    wv_next     = wv;
    a_fill_next = a_fill;
    o_fill_next = o_fill;
    a_full_next = a_full;
    o_full_next = o_full;
    a_base_next = a_base;
    o_base_next = o_base;
    ovf_next    = ovf;
    pushed_next = pushed;
    push_ok     = 1'b0;
    refused     = 1'b0;
    wr_en       = 1'b0;
    wr_sel      = active;
    wr_idx      = a_fill[BAW-1:0];
    if (cmd.clear) begin
      active_next = 1'b0;
      wv_next     = 1'b0;
      a_fill_next = '0;
      o_fill_next = '0;
      a_full_next = 1'b0;
      o_full_next = 1'b0;
      a_base_next = '0;
      o_base_next = '0;
      ovf_next    = '0;
      pushed_next = '0;
    end else if (cmd.push) begin
      if (a_fill == FW'(BUF_DEPTH)) begin
        if (!wv) begin
          // full buffer goes to readout, record starts the other one
          o_fill_next = a_fill;
          o_full_next = 1'b1;
          o_base_next = a_base;
          a_fill_next = FW'(1);
          a_full_next = 1'b0;
          a_base_next = cmd.base;
          active_next = ~active;
          wv_next     = 1'b1;
          wr_en       = 1'b1;
          wr_sel      = ~active;
          wr_idx      = '0;
          pushed_next = pushed + 32'd1;
          push_ok     = 1'b1;
        end else begin
          refused  = 1'b1;
          ovf_next = ovf + (cmd.flush ? 32'd2 : 32'd1);
        end
      end else begin
        if (a_fill == '0) begin
          a_base_next = cmd.base;
        end
        wr_en       = 1'b1;
        a_fill_next = a_fill + FW'(1);
        pushed_next = pushed + 32'd1;
        push_ok     = 1'b1;
        if (a_fill == FW'(BUF_DEPTH - 1)) begin
          a_full_next = 1'b1;
        end
      end
    end else if (cmd.swap) begin
      if (a_fill != '0 && !wv) begin
        o_fill_next = a_fill;
        o_full_next = 1'b1;
        o_base_next = a_base;
        a_fill_next = '0;
        a_full_next = 1'b0;
        a_base_next = o_base;
        active_next = ~active;
        wv_next     = 1'b1;
      end
    end else if (cmd.release_buf) begin
      if (wv) begin
        o_fill_next = '0;
        o_full_next = 1'b0;
        wv_next     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      wv     <= 1'b0;
      a_fill <= '0;
      o_fill <= '0;
      a_full <= 1'b0;
      o_full <= 1'b0;
      a_base <= '0;
      o_base <= '0;
      ovf    <= '0;
      pushed <= '0;
      rd_hit <= 1'b0;
    end else begin
      active <= active_next;
      wv     <= wv_next;
      a_fill <= a_fill_next;
      o_fill <= o_fill_next;
      a_full <= a_full_next;
      o_full <= o_full_next;
      a_base <= a_base_next;
      o_base <= o_base_next;
      ovf    <= ovf_next;
      pushed <= pushed_next;
      if (cmd.read) begin
        rd_hit <= hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_sel][wr_idx] <= cmd.rec;
    end
    if (cmd.read) begin
      rd_rec <= mem[~active][rd_addr];
    end
  end

  assign stat.push_ok     = push_ok;
  assign stat.refused     = refused;
  assign stat.ready_valid = wv_next;
  assign stat.ready_count = wv_next ? 11'(o_fill_next) : 11'd0;
  assign stat.ready_base  = wv_next ? o_base_next : 64'd0;
  assign stat.active_full = a_full_next;
  assign stat.overflow    = ovf_next;
  assign stat.pushed      = pushed_next;
  assign stat.rd_hit      = rd_hit;
  assign stat.rd_rec      = rd_rec;

  a_full_means_full: assert property (@(posedge clk) disable iff (rst)
    a_full |-> a_fill == FW'(BUF_DEPTH))
    else $error("active buffer marked full below depth");

  fill_in_range: assert property (@(posedge clk) disable iff (rst)
    a_fill <= FW'(BUF_DEPTH) && o_fill <= FW'(BUF_DEPTH))
    else $error("buffer fill count beyond depth");

  idle_other_empty: assert property (@(posedge clk) disable iff (rst)
    !wv |-> (!o_full && o_fill == '0))
    else $error("non-waiting buffer holds records");

endmodule

// ----- sv/pcb_ring.sv -----
// pcb_ring: pre-trigger ring memory with head, fill and replay sequencer
// depends on pcb_pkg; replay reads oldest first, data the cycle after a step

module pcb_ring #(
  parameter int RING_DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  pcb_pkg::ring_cmd_t cmd,
  output pcb_pkg::ring_stat_t stat
);

  localparam int RAW = $clog2(RING_DEPTH);
  localparam int UW  = $clog2(RING_DEPTH + 1);
  localparam int SW  = RAW + 1;

  logic [RAW-1:0] head, ptr, start_idx;
  logic [UW-1:0]  used, used_next, left;
  logic [SW-1:0]  sum;
  pcb_pkg::record_t rd_rec;

  pcb_pkg::record_t mem [RING_DEPTH];

  function automatic logic [RAW-1:0] wrap_inc(input logic [RAW-1:0] x);
    return (x == RAW'(RING_DEPTH - 1)) ? '0 : x + RAW'(1);
  endfunction

  // oldest entry: head minus fill, modulo depth
  assign sum       = SW'(head) + SW'(RING_DEPTH) - SW'(used);
  assign start_idx = (sum >= SW'(RING_DEPTH)) ? RAW'(sum - SW'(RING_DEPTH)) : RAW'(sum);

  always_comb begin
    used_next = used;
    if (cmd.empty) begin
      used_next = '0;
    end else if (cmd.push && used != UW'(RING_DEPTH)) begin
      used_next = used + UW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      used <= '0;
      left <= '0;
    end else begin
      used <= used_next;
      if (cmd.empty) begin
        head <= '0;
        left <= '0;
      end else begin
        if (cmd.push) begin
          head <= wrap_inc(head);
        end
        if (cmd.start) begin
          left <= used;
        end else if (cmd.step) begin
          left <= left - UW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      ptr <= start_idx;
    end else if (cmd.step) begin
      ptr <= wrap_inc(ptr);
    end
    if (cmd.push) begin
      mem[head] <= cmd.rec;
    end
    if (cmd.step) begin
      rd_rec <= mem[ptr];
    end
  end

  assign stat.empty  = (used == '0);
  assign stat.more   = (left != '0);
  assign stat.fill   = 9'(used_next);
  assign stat.rd_rec = rd_rec;

  used_in_range: assert property (@(posedge clk) disable iff (rst)
    used <= UW'(RING_DEPTH))
    else $error("ring fill beyond depth");

  left_within_used: assert property (@(posedge clk) disable iff (rst)
    left <= used)
    else $error("replay count exceeds ring fill");

  step_needs_left: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> left != '0)
    else $error("replay step with nothing left");

endmodule

// ----- sv/pingpong_capture_buffer_with_pretrigger_top.sv -----
// pingpong_capture_buffer_with_pretrigger_top: operation sequencer and status register
// depends on pcb_pkg, pcb_capture_if, pcb_status_if, pcb_store and pcb_ring
//
// Usage: one operation item enters on the capture channel, and exactly one status
// item leaves on the status channel for each, carrying the state after that item.
// Push, ring push, swap, release, clear and the unused code load the status register
// at the acceptance edge, and the status item shows in the cycle after,
// so a stream of pushes runs at one item per cycle while the receiver takes each item.
// A read waits in the read state for the registered read of the record memory.
// A flush of a non-empty ring starts the replay in the acceptance cycle, then runs
// replay cycles with one ring memory read a cycle and each record pushed the
// cycle after its read, then loads the status; a refusal ends it early.
// Capture is not ready while a read or flush is in progress.
// The status register is a single output stage: while the receiver stalls it holds
// the item, and capture is not ready until the item has been taken or is taken
// in that cycle.
// Reset (synchronous, active high) clears all counts, marks, bases and the ring head
// and fill; the memories are not swept, since only written entries are ever read.

module pingpong_capture_buffer_with_pretrigger_top #(
  parameter int BUF_DEPTH  = 1024,
  parameter int RING_DEPTH = 256
) (
  input  logic         clk,
  input  logic         rst,
  pcb_capture_if.sink  capture,
  pcb_status_if.source status
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_FLUSH  = 2'd1;
  localparam logic [1:0] ST_READ   = 2'd2;
  localparam logic [1:0] ST_REPORT = 2'd3;

  logic [1:0] state, state_next;
  logic       pending, pending_next;
  logic       slot_free, accept, load, acc, show_read, stop;
  logic       out_valid;
  pcb_pkg::status_item_t out_q, out_next;
  pcb_pkg::store_cmd_t   store_cmd;
  pcb_pkg::store_stat_t  store_stat;
  pcb_pkg::ring_cmd_t    ring_cmd;
  pcb_pkg::ring_stat_t   ring_stat;

  pcb_store #(.BUF_DEPTH(BUF_DEPTH)) u_store (
    .clk  (clk),
    .rst  (rst),
    .cmd  (store_cmd),
    .stat (store_stat)
  );

  pcb_ring #(.RING_DEPTH(RING_DEPTH)) u_ring (
    .clk  (clk),
    .rst  (rst),
    .cmd  (ring_cmd),
    .stat (ring_stat)
  );

  assign slot_free     = !out_valid || status.ready;
  assign capture.ready = (state == ST_IDLE) && slot_free;
  assign accept        = capture.valid && capture.ready;

  always_comb begin
    store_cmd    = '0;
    ring_cmd     = '0;
    state_next   = state;
    pending_next = pending;
    load         = 1'b0;
    acc          = 1'b0;
    show_read    = 1'b0;
    stop         = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (capture.operation)
            pcb_pkg::OP_PUSH: begin
              store_cmd.push       = 1'b1;
              store_cmd.rec.sample = capture.sample;
              store_cmd.rec.delta  = capture.delta;
              store_cmd.base       = capture.first_base_cycles;
              acc                  = store_stat.push_ok;
              load                 = 1'b1;
            end
            pcb_pkg::OP_RING_PUSH: begin
              ring_cmd.push       = 1'b1;
              ring_cmd.rec.sample = capture.sample;
              ring_cmd.rec.delta  = capture.delta;
              load                = 1'b1;
            end
            pcb_pkg::OP_FLUSH: begin
              if (ring_stat.empty) begin
                load = 1'b1;
              end else begin
                ring_cmd.start = 1'b1;
                pending_next   = 1'b0;
                state_next     = ST_FLUSH;
              end
            end
            pcb_pkg::OP_SWAP: begin
              store_cmd.swap = 1'b1;
              load           = 1'b1;
            end
            pcb_pkg::OP_RELEASE: begin
              store_cmd.release_buf = 1'b1;
              load                  = 1'b1;
            end
            pcb_pkg::OP_READ: begin
              store_cmd.read     = 1'b1;
              store_cmd.rd_index = capture.read_index;
              state_next         = ST_READ;
            end
            pcb_pkg::OP_CLEAR: begin
              store_cmd.clear = 1'b1;
              ring_cmd.empty  = 1'b1;
              load            = 1'b1;
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      ST_FLUSH: begin
        // push the record read last cycle, read the next one
        if (pending) begin
          store_cmd.push  = 1'b1;
          store_cmd.flush = 1'b1;
          store_cmd.rec   = ring_stat.rd_rec;
          store_cmd.base  = '0;
        end
        stop          = pending && store_stat.refused;
        pending_next  = ring_stat.more && !stop;
        ring_cmd.step = ring_stat.more && !stop;
        if (stop || !ring_stat.more) begin
          ring_cmd.empty = 1'b1;
          state_next     = ST_REPORT;
        end
      end
      ST_READ: begin
        if (slot_free) begin
          load       = 1'b1;
          show_read  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_REPORT: begin
        if (slot_free) begin
          load       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_next.accepted       = acc;
    out_next.ready_valid    = store_stat.ready_valid;
    out_next.ready_count    = store_stat.ready_count;
    out_next.ready_base     = store_stat.ready_base;
    out_next.read_sample    = (show_read && store_stat.rd_hit) ? store_stat.rd_rec.sample
                                                                : 16'd0;
    out_next.read_delta     = (show_read && store_stat.rd_hit) ? store_stat.rd_rec.delta
                                                                : 32'd0;
    out_next.active_full    = store_stat.active_full;
    out_next.ring_fill      = ring_stat.fill;
    out_next.overflow_total = store_stat.overflow;
    out_next.pushed_total   = store_stat.pushed;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pending   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      pending <= pending_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (status.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_q <= out_next;
    end
  end

  assign status.valid          = out_valid;
  assign status.accepted       = out_q.accepted;
  assign status.ready_valid    = out_q.ready_valid;
  assign status.ready_count    = out_q.ready_count;
  assign status.ready_base     = out_q.ready_base;
  assign status.read_sample    = out_q.read_sample;
  assign status.read_delta     = out_q.read_delta;
  assign status.active_full    = out_q.active_full;
  assign status.ring_fill      = out_q.ring_fill;
  assign status.overflow_total = out_q.overflow_total;
  assign status.pushed_total   = out_q.pushed_total;

endmodule

// ----- dv/pingpong_capture_buffer_with_pretrigger_top_tb.sv -----
// testbench for pingpong_capture_buffer_with_pretrigger_top: directed, full-buffer and random
// items, checked against a predictor of the capture store and ring
// depends on pcb_pkg, pcb_capture_if, pcb_status_if and the top level

module pingpong_capture_buffer_with_pretrigger_top_tb;

  localparam int BUF_ENTRIES = 1024;
  localparam int RING_ENTRIES = 256;
  localparam logic [2:0] OP_UNUSED = 3'd7;

  logic clk = 1'b0;
  logic rst;
  int idle_pct;
  int stall_pct;
  int fail_count = 0;

  pcb_capture_if capture_ch();
  pcb_status_if status_ch();

  pingpong_capture_buffer_with_pretrigger_top #(
    .BUF_DEPTH(BUF_ENTRIES),
    .RING_DEPTH(RING_ENTRIES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .capture(capture_ch),
    .status(status_ch)
  );

  // predicted state of the capture store and ring
  pcb_pkg::record_t buf_rec [2][BUF_ENTRIES];
  int buf_level [2];
  logic buf_full [2];
  logic [63:0] buf_base [2];
  int cur_buf;
  int held_buf;
  logic held_valid;
  pcb_pkg::record_t ring_rec [RING_ENTRIES];
  int ring_wptr;
  int ring_level;
  logic [31:0] refused_count;
  logic [31:0] stored_count;
  pcb_pkg::status_item_t status_expected [$];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void clear_model();
    foreach (buf_level[i]) begin
      buf_level[i] = 0;
      buf_full[i] = 1'b0;
      buf_base[i] = '0;
    end
    cur_buf = 0;
    held_buf = 0;
    held_valid = 1'b0;
    ring_wptr = 0;
    ring_level = 0;
    refused_count = '0;
    stored_count = '0;
  endfunction

  function automatic bit store_record(pcb_pkg::record_t rec, logic [63:0] b);
    int a;
    a = cur_buf;
    if (buf_level[a] == 0) buf_base[a] = b;
    if (buf_level[a] >= BUF_ENTRIES) begin
      if (!held_valid) begin
        // full buffer goes out for readout, the other restarts with this record
        buf_full[a] = 1'b1;
        held_valid = 1'b1;
        held_buf = a;
        a ^= 1;
        cur_buf = a;
        buf_full[a] = 1'b0;
        buf_base[a] = b;
        buf_rec[a][0] = rec;
        buf_level[a] = 1;
        stored_count++;
        return 1'b1;
      end
      refused_count++;
      return 1'b0;
    end
    buf_rec[a][buf_level[a]] = rec;
    buf_level[a]++;
    stored_count++;
    if (buf_level[a] >= BUF_ENTRIES) buf_full[a] = 1'b1;
    return 1'b1;
  endfunction

  function automatic void replay_ring();
    int oldest;
    if (ring_level == 0) return;
    oldest = (ring_wptr + RING_ENTRIES - ring_level) % RING_ENTRIES;
    for (int i = 0; i < ring_level; i++) begin
      if (!store_record(ring_rec[(oldest + i) % RING_ENTRIES], 64'd0)) begin
        refused_count++;
        break;
      end
    end
    ring_level = 0;
    ring_wptr = 0;
  endfunction

  function automatic pcb_pkg::status_item_t status_after(logic [2:0] op, logic [15:0] s,
                                                         logic [31:0] d, logic [63:0] b,
                                                         logic [9:0] idx);
    pcb_pkg::status_item_t st;
    pcb_pkg::record_t rec;
    st = '0;
    rec = {s, d};
    case (op)
      pcb_pkg::OP_PUSH: st.accepted = store_record(rec, b);
      pcb_pkg::OP_RING_PUSH: begin
        ring_rec[ring_wptr] = rec;
        ring_wptr = (ring_wptr + 1) % RING_ENTRIES;
        if (ring_level < RING_ENTRIES) ring_level++;
      end
      pcb_pkg::OP_FLUSH: replay_ring();
      pcb_pkg::OP_SWAP: if (buf_level[cur_buf] > 0 && !held_valid) begin
        buf_full[cur_buf] = 1'b1;
        held_valid = 1'b1;
        held_buf = cur_buf;
        cur_buf ^= 1;
        buf_level[cur_buf] = 0;
        buf_full[cur_buf] = 1'b0;
      end
      pcb_pkg::OP_RELEASE: if (held_valid) begin
        buf_level[held_buf] = 0;
        buf_full[held_buf] = 1'b0;
        held_valid = 1'b0;
      end
      pcb_pkg::OP_READ: if (held_valid && int'(idx) < buf_level[held_buf]) begin
        st.read_sample = buf_rec[held_buf][idx].sample;
        st.read_delta = buf_rec[held_buf][idx].delta;
      end
      pcb_pkg::OP_CLEAR: clear_model();
      default: ;
    endcase
    st.ready_valid = held_valid;
    if (held_valid) begin
      st.ready_count = 11'(buf_level[held_buf]);
      st.ready_base = buf_base[held_buf];
    end
    st.active_full = buf_full[cur_buf];
    st.ring_fill = 9'(ring_level);
    st.overflow_total = refused_count;
    st.pushed_total = stored_count;
    return st;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  function automatic void set_idling(int sender_pct, int receiver_pct);
    idle_pct = sender_pct;
    stall_pct = receiver_pct;
  endfunction

  function automatic logic [2:0] pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return pcb_pkg::OP_PUSH;
    if (r < 52) return pcb_pkg::OP_RING_PUSH;
    if (r < 57) return pcb_pkg::OP_FLUSH;
    if (r < 65) return pcb_pkg::OP_SWAP;
    if (r < 73) return pcb_pkg::OP_RELEASE;
    if (r < 95) return pcb_pkg::OP_READ;
    if (r < 97) return pcb_pkg::OP_CLEAR;
    return OP_UNUSED;
  endfunction

  task automatic send(input logic [2:0] op, input logic [15:0] s, input logic [31:0] d,
                      input logic [63:0] b, input logic [9:0] idx);
    if ($urandom_range(0, 99) < idle_pct) begin
      capture_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
    capture_ch.valid <= 1'b1;
    capture_ch.operation <= op;
    capture_ch.sample <= s;
    capture_ch.delta <= d;
    capture_ch.first_base_cycles <= b;
    capture_ch.read_index <= idx;
    do @(posedge clk); while (!capture_ch.ready);
    status_expected.push_back(status_after(op, s, d, b, idx));
  endtask

  task automatic send_rand(input logic [2:0] op);
    logic [9:0] idx;
    idx = 10'($urandom_range(0, 1023));
    // reads mostly land on held entries
    if (op == pcb_pkg::OP_READ && held_valid && $urandom_range(0, 3) != 0)
      idx = 10'($urandom_range(0, buf_level[held_buf] - 1));
    send(op, 16'($urandom), 32'($urandom), {32'($urandom), 32'($urandom)}, idx);
  endtask

  task automatic wait_for_status();
    capture_ch.valid <= 1'b0;
    while (status_expected.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    set_idling(0, 0);
    send(pcb_pkg::OP_READ, 16'h0, 32'h0, 64'h0, 10'd0);
    send(pcb_pkg::OP_RELEASE, 16'h0, 32'h0, 64'h0, 10'd0);
    send(pcb_pkg::OP_SWAP, 16'h0, 32'h0, 64'h0, 10'd0);
    send(pcb_pkg::OP_FLUSH, 16'h0, 32'h0, 64'h0, 10'd0);
    send(pcb_pkg::OP_PUSH, 16'hffff, 32'hffff_ffff, 64'hffff_ffff_ffff_ffff, 10'd1023);
    send(pcb_pkg::OP_PUSH, 16'h0, 32'h0, 64'h0, 10'd0);
    send(pcb_pkg::OP_PUSH, 16'h5555, 32'haaaa_aaaa, 64'h5555_5555_5555_5555, 10'h2aa);
    send(pcb_pkg::OP_RING_PUSH, 16'haaaa, 32'h5555_5555, 64'haaaa_aaaa_aaaa_aaaa, 10'h155);
    send(pcb_pkg::OP_RING_PUSH, 16'hffff, 32'hffff_ffff, 64'h0, 10'd0);
    send(pcb_pkg::OP_SWAP, 16'h0, 32'h0, 64'h0, 10'd0);
    send(pcb_pkg::OP_SWAP, 16'h0, 32'h0, 64'h0, 10'd0);
    send(pcb_pkg::OP_READ, 16'h0, 32'h0, 64'h0, 10'd0);
    send(pcb_pkg::OP_READ, 16'h0, 32'h0, 64'h0, 10'd1);
    send(pcb_pkg::OP_READ, 16'h0, 32'h0, 64'h0, 10'd2);
    send(pcb_pkg::OP_READ, 16'h0, 32'h0, 64'h0, 10'd3);
    send(pcb_pkg::OP_READ, 16'h0, 32'h0, 64'h0, 10'd1023);
    send(pcb_pkg::OP_FLUSH, 16'h0, 32'h0, 64'h0, 10'd0);
    send(OP_UNUSED, 16'hffff, 32'hffff_ffff, 64'hffff_ffff_ffff_ffff, 10'd1023);
    send(pcb_pkg::OP_RELEASE, 16'h0, 32'h0, 64'h0, 10'd0);
    send(pcb_pkg::OP_READ, 16'h0, 32'h0, 64'h0, 10'd0);
    send(pcb_pkg::OP_SWAP, 16'h0, 32'h0, 64'h0, 10'd0);
    send(pcb_pkg::OP_READ, 16'h0, 32'h0, 64'h0, 10'd1);
    send(pcb_pkg::OP_CLEAR, 16'h0, 32'h0, 64'h0, 10'd0);
    send(pcb_pkg::OP_READ, 16'h0, 32'h0, 64'h0, 10'd0);
  endtask

  task automatic test_buffers_full();
    set_idling(0, 0);
    // ring wraps and overwrites its oldest records
    repeat (RING_ENTRIES + 4) send_rand(pcb_pkg::OP_RING_PUSH);
    // a one-record buffer waits while the other fills
    send_rand(pcb_pkg::OP_PUSH);
    send_rand(pcb_pkg::OP_SWAP);
    while (buf_level[cur_buf] < BUF_ENTRIES / 2) send_rand(pcb_pkg::OP_PUSH);
    set_idling(10, 10);
    while (buf_level[cur_buf] < BUF_ENTRIES) send_rand(pcb_pkg::OP_PUSH);
    set_idling(47, 0);
    repeat (3) send_rand(pcb_pkg::OP_PUSH);
    send(pcb_pkg::OP_READ, 16'h0, 32'h0, 64'h0, 10'd0);
    send(pcb_pkg::OP_READ, 16'h0, 32'h0, 64'h0, 10'd1023);
    repeat (5) send_rand(pcb_pkg::OP_READ);
    wait_for_status();
    // both buffers full: the flush is refused on its first record
    send_rand(pcb_pkg::OP_FLUSH);
    send_rand(pcb_pkg::OP_FLUSH);
    set_idling(0, 47);
    send_rand(pcb_pkg::OP_RELEASE);
    // full active buffer with nothing waiting swaps on push
    send_rand(pcb_pkg::OP_PUSH);
    repeat (4) send_rand(pcb_pkg::OP_RING_PUSH);
    send_rand(pcb_pkg::OP_FLUSH);
    repeat (10) send_rand(pcb_pkg::OP_READ);
    send_rand(pcb_pkg::OP_RELEASE);
    send_rand(pcb_pkg::OP_SWAP);
    repeat (10) send_rand(pcb_pkg::OP_READ);
    send_rand(pcb_pkg::OP_CLEAR);
  endtask

  task automatic test_random_mix();
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_idling(0, 0);
        1: set_idling(47, 0);
        2: set_idling(0, 47);
        default: set_idling(10, 10);
      endcase
      repeat (20) send_rand(pick_op());
    end
  endtask

  always @(posedge clk) status_ch.ready <= ($urandom_range(0, 99) >= stall_pct);

  always @(posedge clk) begin : status_check
    pcb_pkg::status_item_t want;
    if (!rst && status_ch.valid && status_ch.ready) begin
      if (status_expected.size() == 0) begin
        $error("status item with nothing outstanding");
        fail_count++;
      end else begin
        want = status_expected.pop_front();
        check_field("accepted", 64'(want.accepted), 64'(status_ch.accepted));
        check_field("ready_valid", 64'(want.ready_valid), 64'(status_ch.ready_valid));
        check_field("ready_count", 64'(want.ready_count), 64'(status_ch.ready_count));
        check_field("ready_base", want.ready_base, status_ch.ready_base);
        check_field("read_sample", 64'(want.read_sample), 64'(status_ch.read_sample));
        check_field("read_delta", 64'(want.read_delta), 64'(status_ch.read_delta));
        check_field("active_full", 64'(want.active_full), 64'(status_ch.active_full));
        check_field("ring_fill", 64'(want.ring_fill), 64'(status_ch.ring_fill));
        check_field("overflow_total", 64'(want.overflow_total),
                    64'(status_ch.overflow_total));
        check_field("pushed_total", 64'(want.pushed_total), 64'(status_ch.pushed_total));
      end
    end
  end

  initial begin
    #24000000;
    $display("FAIL");
    $finish;
  end

  initial begin
    clear_model();
    set_idling(0, 0);
    rst <= 1'b1;
    capture_ch.valid <= 1'b0;
    capture_ch.operation <= pcb_pkg::OP_PUSH;
    capture_ch.sample <= '0;
    capture_ch.delta <= '0;
    capture_ch.first_base_cycles <= '0;
    capture_ch.read_index <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_buffers_full();
    test_random_mix();
    wait_for_status();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
